// ----- rtl/hid_key_event_to_keysym_assert.svh -----
// Assertion macros shared by the RTL. They compile away under SYNTHESIS.
`ifndef HID_KEY_EVENT_TO_KEYSYM_ASSERT_SVH
`define HID_KEY_EVENT_TO_KEYSYM_ASSERT_SVH

`ifndef SYNTHESIS
`define HKS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HKS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HKS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define HKS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/hks_pkg.sv -----
`timescale 1ns / 1ps

package hks_pkg;

    typedef logic [7:0]  usage_code_t;
    typedef logic [15:0] keysym_t;
    typedef logic [7:0]  char_t;
    typedef logic [4:0]  mod_mask_t;

    localparam int MOD_SHIFT = 0;
    localparam int MOD_CAPS  = 1;
    localparam int MOD_CTRL  = 2;
    localparam int MOD_ALT   = 3;
    localparam int MOD_LOGO  = 4;

    localparam usage_code_t HID_LIMIT   = 8'd232;
    localparam usage_code_t KEY_CAPS    = 8'd57;
    localparam usage_code_t KEY_LCTRL   = 8'd224;
    localparam usage_code_t KEY_LSHIFT  = 8'd225;
    localparam usage_code_t KEY_LALT    = 8'd226;
    localparam usage_code_t KEY_LLOGO   = 8'd227;
    localparam usage_code_t KEY_RCTRL   = 8'd228;
    localparam usage_code_t KEY_RSHIFT  = 8'd229;
    localparam usage_code_t KEY_RALT    = 8'd230;
    localparam usage_code_t KEY_RLOGO   = 8'd231;

    function automatic char_t digit_sym(input logic [3:0] n);
        char_t c;
        case (n)
            4'd0: c = 8'h21;
            4'd1: c = 8'h40;
            4'd2: c = 8'h23;
            4'd3: c = 8'h24;
            4'd4: c = 8'h25;
            4'd5: c = 8'h5e;
            4'd6: c = 8'h26;
            4'd7: c = 8'h2a;
            4'd8: c = 8'h28;
            4'd9: c = 8'h29;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic keysym_t us_map(input usage_code_t code, input logic sh);
        keysym_t sym;
        case (code)
            8'd40:  sym = 16'hff0d;
            8'd41:  sym = 16'hff1b;
            8'd42:  sym = 16'hff08;
            8'd43:  sym = sh ? 16'hfe20 : 16'hff09;
            8'd44:  sym = 16'h0020;
            8'd45:  sym = sh ? 16'h005f : 16'h002d;
            8'd46:  sym = sh ? 16'h002b : 16'h003d;
            8'd47:  sym = sh ? 16'h007b : 16'h005b;
            8'd48:  sym = sh ? 16'h007d : 16'h005d;
            8'd49:  sym = sh ? 16'h007c : 16'h005c;
            8'd50:  sym = sh ? 16'h007c : 16'h005c;
            8'd51:  sym = sh ? 16'h003a : 16'h003b;
            8'd52:  sym = sh ? 16'h0022 : 16'h0027;
            8'd53:  sym = sh ? 16'h007e : 16'h0060;
            8'd54:  sym = sh ? 16'h003c : 16'h002c;
            8'd55:  sym = sh ? 16'h003e : 16'h002e;
            8'd56:  sym = sh ? 16'h003f : 16'h002f;
            8'd57:  sym = 16'hffe5;
            8'd70:  sym = 16'hff61;
            8'd71:  sym = 16'hff14;
            8'd72:  sym = 16'hff13;
            8'd73:  sym = 16'hff63;
            8'd74:  sym = 16'hff50;
            8'd75:  sym = 16'hff55;
            8'd76:  sym = 16'hffff;
            8'd77:  sym = 16'hff57;
            8'd78:  sym = 16'hff56;
            8'd79:  sym = 16'hff53;
            8'd80:  sym = 16'hff51;
            8'd81:  sym = 16'hff54;
            8'd82:  sym = 16'hff52;
            8'd83:  sym = 16'hff7f;
            8'd84:  sym = 16'hffaf;
            8'd85:  sym = 16'hffaa;
            8'd86:  sym = 16'hffad;
            8'd87:  sym = 16'hffab;
            8'd88:  sym = 16'hff8d;
            8'd99:  sym = 16'hffae;
            8'd224: sym = 16'hffe3;
            8'd225: sym = 16'hffe1;
            8'd226: sym = 16'hffe9;
            8'd227: sym = 16'hffeb;
            8'd228: sym = 16'hffe4;
            8'd229: sym = 16'hffe2;
            8'd230: sym = 16'hffea;
            8'd231: sym = 16'hffec;
            default: sym = 16'h0000;
        endcase
        return sym;
    endfunction

    function automatic keysym_t lookup_sym(input usage_code_t code, input mod_mask_t mods);
        logic        sh;
        logic        cp;
        usage_code_t off;
        keysym_t     sym;
        sh = mods[MOD_SHIFT];
        cp = mods[MOD_CAPS];
        if (code >= 8'd4 && code <= 8'd29) begin
            off = code - 8'd4;
            sym = (sh ^ cp) ? {8'h00, 8'(8'h41 + off)} : {8'h00, 8'(8'h61 + off)};
        end else if (code >= 8'd30 && code <= 8'd39) begin
            off = code - 8'd30;
            if (sh) begin
                sym = {8'h00, digit_sym(off[3:0])};
            end else if (code == 8'd39) begin
                sym = 16'h0030;
            end else begin
                sym = {8'h00, 8'(8'h31 + off)};
            end
        end else if (code >= 8'd89 && code <= 8'd97) begin
            off = code - 8'd89;
            sym = 16'hffb1 + {8'h00, off};
        end else if (code == 8'd98) begin
            off = 8'h00;
            sym = 16'hffb0;
        end else if (code >= 8'd58 && code <= 8'd69) begin
            off = code - 8'd58;
            sym = 16'hffbe + {8'h00, off};
        end else if (code >= HID_LIMIT) begin
            off = 8'h00;
            sym = 16'h0000;
        end else begin
            off = 8'h00;
            sym = us_map(code, sh);
        end
        return sym;
    endfunction

    function automatic char_t sym_char(input keysym_t sym);
        char_t c;
        if (sym >= 16'h0020 && sym <= 16'h007e) begin
            c = sym[7:0];
        end else if (sym >= 16'h00a0 && sym <= 16'h00ff) begin
            c = sym[7:0];
        end else if (sym >= 16'hffb0 && sym <= 16'hffb9) begin
            c = 8'h30 + {4'h0, sym[3:0]};
        end else begin
            case (sym)
                16'hff08: c = 8'h08;
                16'hff09: c = 8'h09;
                16'hff0a: c = 8'h0a;
                16'hff0b: c = 8'h0b;
                16'hff0d: c = 8'h0d;
                16'hff1b: c = 8'h1b;
                16'hffff: c = 8'h7f;
                16'hff80: c = 8'h20;
                16'hff89: c = 8'h09;
                16'hff8d: c = 8'h0d;
                16'hffbd: c = 8'h3d;
                16'hffaa: c = 8'h2a;
                16'hffab: c = 8'h2b;
                16'hffac: c = 8'h2c;
                16'hffad: c = 8'h2d;
                16'hffae: c = 8'h2e;
                16'hffaf: c = 8'h2f;
                default:  c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic mod_mask_t next_mods(input mod_mask_t held, input usage_code_t code,
                                            input logic press);
        mod_mask_t bits;
        mod_mask_t res;
        bits = '0;
        case (code)
            KEY_LCTRL, KEY_RCTRL:   bits[MOD_CTRL]  = 1'b1;
            KEY_LSHIFT, KEY_RSHIFT: bits[MOD_SHIFT] = 1'b1;
            KEY_LALT, KEY_RALT:     bits[MOD_ALT]   = 1'b1;
            KEY_LLOGO, KEY_RLOGO:   bits[MOD_LOGO]  = 1'b1;
            default:                bits = '0;
        endcase
        if (code == KEY_CAPS) begin
            res = held;
            if (press) begin
                res[MOD_CAPS] = ~held[MOD_CAPS];
            end
        end else if (press) begin
            res = held | bits;
        end else begin
            res = held & ~bits;
        end
        return res;
    endfunction

    function automatic logic is_mod_key(input usage_code_t code);
        return (code == KEY_CAPS) || (code >= KEY_LCTRL && code <= KEY_RLOGO);
    endfunction

endpackage

// ----- rtl/hid_key_event_to_keysym.sv -----
// A word accepted at s_ passes through the input register and then the result register
// before it appears on m_; one word can be accepted every cycle while the result register
// is not held full by m_ready low.
// The modifier mask register updates as a word moves from the input register to the
// result register, so consecutive words see each other's modifier changes without gaps.
// Reset (aresetn low at a clock edge) empties both registers and clears the mask.
`timescale 1ns / 1ps

`include "hid_key_event_to_keysym_assert.svh"

module hid_key_event_to_keysym (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  hks_pkg::usage_code_t        s_usage_code,
    input  logic                        s_is_press,
    output logic                        m_valid,
    input  logic                        m_ready,
    output hks_pkg::keysym_t            m_keysym,
    output hks_pkg::char_t              m_character,
    output hks_pkg::mod_mask_t          m_modifier_mask
);

    logic                 in_valid_reg, in_valid_next;
    hks_pkg::usage_code_t in_code_reg, in_code_next;
    logic                 in_press_reg, in_press_next;

    logic                 out_valid_reg, out_valid_next;
    hks_pkg::keysym_t     out_sym_reg, out_sym_next;
    hks_pkg::char_t       out_char_reg, out_char_next;
    hks_pkg::mod_mask_t   held_reg, held_next;

    logic                 advance;
    hks_pkg::keysym_t     sym;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign sym     = hks_pkg::lookup_sym(in_code_reg, held_reg);

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_code_next   = in_code_reg;
        in_press_next  = in_press_reg;
        out_valid_next = out_valid_reg;
        out_sym_next   = out_sym_reg;
        out_char_next  = out_char_reg;
        held_next      = held_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_code_next  = s_usage_code;
            in_press_next = s_is_press;
        end
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            out_sym_next   = sym;
            out_char_next  = hks_pkg::sym_char(sym);
            held_next      = hks_pkg::next_mods(held_reg, in_code_reg, in_press_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_code_reg  <= in_code_next;
        in_press_reg <= in_press_next;
        out_sym_reg  <= out_sym_next;
        out_char_reg <= out_char_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_keysym        = out_sym_reg;
    assign m_character     = out_char_reg;
    assign m_modifier_mask = held_reg;

    `HKS_ASSERT_IMP(a_mask_matches_held, aclk, aresetn, out_valid_reg, m_modifier_mask == held_reg)
    `HKS_ASSERT_NXT(a_plain_key_keeps_mask, aclk, aresetn, advance && !hks_pkg::is_mod_key(in_code_reg), held_reg == $past(held_reg))
    `HKS_ASSERT_NXT(a_high_code_no_sym, aclk, aresetn, advance && (in_code_reg >= hks_pkg::HID_LIMIT), (out_sym_reg == 16'h0000) && (out_char_reg == 8'h00))
    `HKS_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready)

endmodule
